// File: hdl/slmc_pkg.sv
// shared types and constants for the status led mode controller
package slmc_pkg;

    typedef enum logic [3:0] {
        MODE_BOOT    = 4'd0,
        MODE_BADHW   = 4'd1,
        MODE_PAIR    = 4'd2,
        MODE_UNPROV  = 4'd3,
        MODE_TROUBLE = 4'd4,
        MODE_PAUSED  = 4'd5,
        MODE_NORMAL  = 4'd6,
        MODE_VOICE   = 4'd7,
        MODE_FACTORY = 4'd8,
        MODE_NONE    = 4'd9
    } t_mode;

    typedef enum logic [1:0] {
        LINK_CONNECTED    = 2'd0,
        LINK_DISCONNECTED = 2'd1,
        LINK_PAUSED       = 2'd2,
        LINK_OTHER        = 2'd3
    } t_link;

    localparam int unsigned CountWidth = 4;
    localparam logic [CountWidth-1:0] DebounceReset = 4'd5;

endpackage

// File: hdl/slmc_tick_if.sv
// poll tick channel and led mode result channel
interface slmc_tick_if;
    logic       valid;
    logic       ready;
    logic [1:0] link_mode;
    logic       bad_hardware;
    logic       boot_done;
    logic       pairing_active;
    logic       provisioned;
    logic       provisioned_onboard;
    logic       pair_request;
    logic       voice_active;
    logic       peer_link;

    modport source (
        output valid, link_mode, bad_hardware, boot_done, pairing_active, provisioned,
               provisioned_onboard, pair_request, voice_active, peer_link,
        input  ready
    );
    modport sink (
        input  valid, link_mode, bad_hardware, boot_done, pairing_active, provisioned,
               provisioned_onboard, pair_request, voice_active, peer_link,
        output ready
    );
endinterface

interface slmc_led_if;
    logic       valid;
    logic       ready;
    logic [3:0] led_mode;
    logic       apply;

    modport source (output valid, led_mode, apply, input ready);
    modport sink (input valid, led_mode, apply, output ready);
endinterface

// File: hdl/status_led_mode_controller_top.sv
// status led mode controller: poll ticks in, led mode and apply flag out
//
// usage:
//   i_tick carries one poll beat: link mode plus status flags. o_led carries
//   one result beat per tick: the led mode pending before the tick and an
//   apply flag, set when that mode differs from the mode last shown or when
//   the peer link changed.
//   i_cfg_we / i_cfg_wdata write the debounce limit (polls a disconnect or
//   pause must persist); write only while no result is outstanding.
// timing and throughput:
//   a result beat appears in the cycle after its tick is accepted; one tick is
//   taken every cycle while o_led is not stalled, since the mode rules, counters
//   and compare all sit between the state registers and the result register.
// reset (synchronous, active low):
//   pending mode is boot, no mode shown yet, counters and peer link cleared,
//   debounce limit 5, result register empty.
// stall:
//   the result register holds its beat while o_led.ready is low; a new tick
//   is taken in the same cycle the held beat leaves, never while it waits.
module status_led_mode_controller_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_wdata,
    slmc_tick_if.sink      i_tick,
    slmc_led_if.source     o_led
);
    import slmc_pkg::*;

    // state
    logic [CountWidth-1:0] r_limit;
    t_mode                 r_pending_mode;
    t_mode                 r_shown_mode;
    logic [CountWidth-1:0] r_offline_count;
    logic [CountWidth-1:0] r_pause_count;
    logic                  r_last_peer;

    // result register
    logic       r_out_valid;
    logic [3:0] r_led_mode;
    logic       r_apply;

    logic                  tick_acc;
    logic                  n_apply;
    logic                  conn;
    logic                  paus;
    logic [CountWidth-1:0] n_offline_count;
    logic [CountWidth-1:0] n_pause_count;
    t_mode                 n_pending_mode;

    // per-mode priority rules
    function automatic t_mode next_mode(t_mode cur, logic c, logic p, logic badhw,
                                        logic booting, logic pairing, logic notprov,
                                        logic notonb, logic bt, logic voice);
        t_mode m;
        logic  offl;
        offl = !c;
        m    = MODE_BOOT;
        unique case (cur)
            MODE_BOOT: begin
                if (badhw)                 m = MODE_BADHW;
                else if (booting)          m = MODE_BOOT;
                else if (pairing && notprov) m = MODE_PAIR;
                else if (!notprov && offl) m = MODE_TROUBLE;
                else if (c && !notprov)    m = MODE_NORMAL;
                else                       m = MODE_BOOT;
            end
            MODE_BADHW:   m = MODE_BADHW;
            MODE_PAIR: begin
                if (bt || (pairing && notonb)) m = MODE_PAIR;
                else if (!notonb && offl)  m = MODE_TROUBLE;
                else if (c && !notonb)     m = MODE_NORMAL;
                else                       m = MODE_PAIR;
            end
            MODE_UNPROV: begin
                if (pairing)               m = MODE_PAIR;
                else if (c && notprov)     m = MODE_UNPROV;
                else if (c && !notprov)    m = MODE_NORMAL;
                else if (offl)             m = MODE_TROUBLE;
                else                       m = MODE_UNPROV;
            end
            MODE_TROUBLE: begin
                if (bt)                    m = MODE_PAIR;
                else if (p)                m = MODE_PAUSED;
                else if (c)                m = MODE_NORMAL;
                else                       m = MODE_TROUBLE;
            end
            MODE_PAUSED: begin
                if (bt)                    m = MODE_PAIR;
                else if (!p && offl)       m = MODE_TROUBLE;
                else if (!p && c)          m = MODE_NORMAL;
                else if (!p && voice)      m = MODE_VOICE;
                else                       m = MODE_PAUSED;
            end
            MODE_NORMAL: begin
                if (bt)                    m = MODE_PAIR;
                else if (p && !voice)      m = MODE_PAUSED;
                else if (offl && !voice)   m = MODE_TROUBLE;
                else if (!p && voice)      m = MODE_VOICE;
                else                       m = MODE_NORMAL;
            end
            MODE_VOICE: begin
                if (p && !voice)           m = MODE_PAUSED;
                else if (c && !voice)      m = MODE_NORMAL;
                else if (!notprov && offl) m = MODE_TROUBLE;
                else                       m = MODE_VOICE;
            end
            MODE_FACTORY: m = MODE_FACTORY;
            default:      m = MODE_BOOT;
        endcase
        return m;
    endfunction

    // take a tick whenever the result register is free or draining
    assign i_tick.ready = !r_out_valid || o_led.ready;
    assign tick_acc     = i_tick.valid && i_tick.ready;

    assign o_led.valid    = r_out_valid;
    assign o_led.led_mode = r_led_mode;
    assign o_led.apply    = r_apply;

    always_comb begin
        n_apply = (r_pending_mode != r_shown_mode) || (i_tick.peer_link != r_last_peer);

        // debounced predicates from the counters as they stand before the tick
        conn = !((t_link'(i_tick.link_mode) == LINK_DISCONNECTED) &&
                 (r_offline_count >= r_limit));
        paus = (t_link'(i_tick.link_mode) == LINK_PAUSED) && (r_pause_count >= r_limit);

        n_offline_count = r_offline_count;
        n_pause_count   = r_pause_count;
        unique case (t_link'(i_tick.link_mode))
            LINK_CONNECTED: begin
                n_offline_count = '0;
                n_pause_count   = '0;
            end
            LINK_DISCONNECTED: begin
                n_pause_count = '0;
                if (r_offline_count < r_limit) begin
                    n_offline_count = r_offline_count + 1'b1;
                end
            end
            LINK_PAUSED: begin
                n_offline_count = '0;
                if (r_pause_count < r_limit) begin
                    n_pause_count = r_pause_count + 1'b1;
                end
            end
            default: begin
                n_pause_count = '0;
            end
        endcase

        // shown mode equals pending mode once latched
        n_pending_mode = next_mode(r_pending_mode, conn, paus, i_tick.bad_hardware,
                                   !i_tick.boot_done, i_tick.pairing_active,
                                   !i_tick.provisioned, !i_tick.provisioned_onboard,
                                   i_tick.pair_request, i_tick.voice_active);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit         <= DebounceReset;
            r_pending_mode  <= MODE_BOOT;
            r_shown_mode    <= MODE_NONE;
            r_offline_count <= '0;
            r_pause_count   <= '0;
            r_last_peer     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (tick_acc) begin
                r_shown_mode    <= r_pending_mode;
                r_last_peer     <= i_tick.peer_link;
                r_offline_count <= n_offline_count;
                r_pause_count   <= n_pause_count;
                r_pending_mode  <= n_pending_mode;
                r_out_valid     <= 1'b1;
            end else if (o_led.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted tick
    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_led_mode <= r_pending_mode;
            r_apply    <= n_apply;
        end
    end

    // every accepted tick leaves a result beat behind it
    a_tick_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> r_out_valid)
        else $error("accepted tick left no result beat");

    // pending mode never takes the none-shown code or an undefined one
    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending_mode <= MODE_FACTORY)
        else $error("pending mode out of range");

    // bad hardware and factory modes are absorbing
    a_absorbing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc && (r_pending_mode == MODE_BADHW || r_pending_mode == MODE_FACTORY)
        |=> r_pending_mode == $past(r_pending_mode))
        else $error("absorbing mode left");

    // no change of mode or peer link means no apply
    a_no_spurious_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc && (r_pending_mode == r_shown_mode) && (i_tick.peer_link == r_last_peer)
        |=> !o_led.apply)
        else $error("apply set without a change");

    // after any accepted tick the shown mode is a real mode
    a_shown_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> r_shown_mode != MODE_NONE)
        else $error("shown mode not latched");

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the status led mode controller: poll ticks in, led beats checked
module tb_top;
    import slmc_pkg::*;

    // one poll tick as the sender sees it
    typedef struct packed {
        t_link link;
        logic  bad_hw;
        logic  boot_done;
        logic  pairing;
        logic  prov;
        logic  prov_onb;
        logic  pair_req;
        logic  voice;
        logic  peer;
    } t_tick;

    // one led beat as the receiver should see it
    typedef struct packed {
        t_mode mode;
        logic  apply;
    } t_led;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CountWidth-1:0] cfg_wdata;

    slmc_tick_if tick ();
    slmc_led_if  led ();

    status_led_mode_controller_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_tick      (tick),
        .o_led       (led)
    );

    // ticks waiting to be offered, and led beats still owed by the block
    t_tick tick_q[$];
    t_led  led_q[$];

    // mirror of the block's state and debounce register
    logic [CountWidth-1:0] db_limit   = DebounceReset;
    t_mode                 pend_mode  = MODE_BOOT;
    t_mode                 shown_mode = MODE_NONE;
    logic [CountWidth-1:0] off_cnt    = '0;
    logic [CountWidth-1:0] pau_cnt    = '0;
    logic                  last_peer  = 1'b0;

    int    ticks_pushed = 0;
    int    ticks_taken  = 0;
    int    errors       = 0;
    int    send_gap     = 0;
    int    stall        = 0;
    logic  hold         = 1'b0;
    logic  calm         = 1'b0;
    logic  gen_peer     = 1'b0;
    t_tick cur_tick;

    // per-mode priority rules, from the mode last shown
    function automatic t_mode next_led_mode(t_mode cur, logic conn, logic paus, t_tick t);
        logic  offl;
        logic  booting;
        logic  notprov;
        logic  notonb;
        t_mode nxt;
        offl    = !conn;
        booting = !t.boot_done;
        notprov = !t.prov;
        notonb  = !t.prov_onb;
        case (cur)
            MODE_BOOT: begin
                if (t.bad_hw)                   nxt = MODE_BADHW;
                else if (booting)               nxt = MODE_BOOT;
                else if (t.pairing && notprov)  nxt = MODE_PAIR;
                else if (!notprov && offl)      nxt = MODE_TROUBLE;
                else if (conn && !notprov)      nxt = MODE_NORMAL;
                else                            nxt = MODE_BOOT;
            end
            MODE_BADHW: nxt = MODE_BADHW;
            MODE_PAIR: begin
                if (t.pair_req || (t.pairing && notonb)) nxt = MODE_PAIR;
                else if (!notonb && offl)                nxt = MODE_TROUBLE;
                else if (conn && !notonb)                nxt = MODE_NORMAL;
                else                                     nxt = MODE_PAIR;
            end
            MODE_UNPROV: begin
                if (t.pairing)                  nxt = MODE_PAIR;
                else if (conn && notprov)       nxt = MODE_UNPROV;
                else if (conn && !notprov)      nxt = MODE_NORMAL;
                else if (offl)                  nxt = MODE_TROUBLE;
                else                            nxt = MODE_UNPROV;
            end
            MODE_TROUBLE: begin
                if (t.pair_req)                 nxt = MODE_PAIR;
                else if (paus)                  nxt = MODE_PAUSED;
                else if (conn)                  nxt = MODE_NORMAL;
                else                            nxt = MODE_TROUBLE;
            end
            MODE_PAUSED: begin
                if (t.pair_req)                 nxt = MODE_PAIR;
                else if (!paus && offl)         nxt = MODE_TROUBLE;
                else if (!paus && conn)         nxt = MODE_NORMAL;
                else if (!paus && t.voice)      nxt = MODE_VOICE;
                else                            nxt = MODE_PAUSED;
            end
            MODE_NORMAL: begin
                if (t.pair_req)                 nxt = MODE_PAIR;
                else if (paus && !t.voice)      nxt = MODE_PAUSED;
                else if (offl && !t.voice)      nxt = MODE_TROUBLE;
                else if (!paus && t.voice)      nxt = MODE_VOICE;
                else                            nxt = MODE_NORMAL;
            end
            MODE_VOICE: begin
                if (paus && !t.voice)           nxt = MODE_PAUSED;
                else if (conn && !t.voice)      nxt = MODE_NORMAL;
                else if (!notprov && offl)      nxt = MODE_TROUBLE;
                else                            nxt = MODE_VOICE;
            end
            MODE_FACTORY: nxt = MODE_FACTORY;
            default:      nxt = MODE_BOOT;
        endcase
        return nxt;
    endfunction

    // one poll: report the pending mode, latch it, debounce, pick the next mode
    function automatic t_led advance_status(t_tick t);
        t_led r;
        logic conn;
        logic paus;
        r.mode  = pend_mode;
        r.apply = 1'b0;
        if (pend_mode != shown_mode || t.peer != last_peer) begin
            r.apply    = 1'b1;
            shown_mode = pend_mode;
            last_peer  = t.peer;
        end
        // both predicates use the counters as they stood before this poll
        conn = !(t.link == LINK_DISCONNECTED && off_cnt >= db_limit);
        paus = (t.link == LINK_PAUSED && pau_cnt >= db_limit);
        case (t.link)
            LINK_CONNECTED: begin
                off_cnt = '0;
                pau_cnt = '0;
            end
            LINK_DISCONNECTED: begin
                pau_cnt = '0;
                if (off_cnt < db_limit) off_cnt = off_cnt + 1'b1;
            end
            LINK_PAUSED: begin
                off_cnt = '0;
                if (pau_cnt < db_limit) pau_cnt = pau_cnt + 1'b1;
            end
            default: pau_cnt = '0;
        endcase
        pend_mode = next_led_mode(shown_mode, conn, paus, t);
        return r;
    endfunction

    // flags are {bad_hw, boot_done, pairing, prov, prov_onb, pair_req, voice, peer}
    task automatic push_tick(input t_link l, input logic [7:0] f);
        t_tick t;
        t.link = l;
        {t.bad_hw, t.boot_done, t.pairing, t.prov, t.prov_onb, t.pair_req, t.voice,
         t.peer} = f;
        tick_q.push_back(t);
        ticks_pushed++;
    endtask

    // runs of one link mode around the debounce limit, with some noise mixed in
    task automatic add_runs(input int n);
        int         cnt;
        int         len;
        t_link      l;
        logic       vc;
        logic [9:0] raw;
        t_tick      t;
        cnt = 0;
        while (cnt < n) begin
            l   = t_link'($urandom_range(0, 3));
            len = $urandom_range(1, int'(db_limit) + 3);
            vc  = 1'($urandom_range(0, 1));
            for (int k = 0; k < len && cnt < n; k++) begin
                if ($urandom_range(0, 6) == 0) begin
                    // noise: any link mode and any flags
                    raw    = 10'($urandom);
                    t.link = t_link'(raw[9:8]);
                    {t.bad_hw, t.boot_done, t.pairing, t.prov, t.prov_onb, t.pair_req,
                     t.voice, t.peer} = raw[7:0];
                end else begin
                    if ($urandom_range(0, 3) == 0) gen_peer = !gen_peer;
                    t.link      = l;
                    t.bad_hw    = 1'($urandom_range(0, 1));
                    t.boot_done = 1'($urandom_range(0, 1));
                    t.pairing   = ($urandom_range(0, 3) == 0);
                    t.prov      = 1'($urandom_range(0, 1));
                    t.prov_onb  = ($urandom_range(0, 3) != 0);
                    t.pair_req  = ($urandom_range(0, 7) == 0);
                    t.voice     = vc ^ ($urandom_range(0, 7) == 0);
                    t.peer      = gen_peer;
                end
                tick_q.push_back(t);
                ticks_pushed++;
                cnt++;
            end
        end
    endtask

    // wait until every tick is taken and every led beat has come back
    task automatic drain();
        while (ticks_taken != ticks_pushed || led_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // debounce limit change, only with the block idle
    task automatic run_phase(input logic [CountWidth-1:0] lim, input int n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        db_limit   = lim;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        add_runs(n);
    endtask

    // clock; the single reset at the start comes from the next block
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // every block input known from time zero
    initial begin
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        tick.valid               = 1'b0;
        tick.link_mode           = LINK_CONNECTED;
        tick.bad_hardware        = 1'b0;
        tick.boot_done           = 1'b0;
        tick.pairing_active      = 1'b0;
        tick.provisioned         = 1'b0;
        tick.provisioned_onboard = 1'b0;
        tick.pair_request        = 1'b0;
        tick.voice_active        = 1'b0;
        tick.peer_link           = 1'b0;
        led.ready                = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // tick driver: predicts on every accepted beat, then offers the next one
    always @(posedge i_clk) begin : drive_ticks
        if (!i_rst_n) begin
            tick.valid <= 1'b0;
        end else begin
            if (tick.valid && tick.ready) begin
                led_q.push_back(advance_status(cur_tick));
                ticks_taken++;
            end
            // a beat on offer stays put until it is taken
            if (!tick.valid || tick.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    tick.valid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    cur_tick = tick_q.pop_front();
                    tick.link_mode           <= cur_tick.link;
                    tick.bad_hardware        <= cur_tick.bad_hw;
                    tick.boot_done           <= cur_tick.boot_done;
                    tick.pairing_active      <= cur_tick.pairing;
                    tick.provisioned         <= cur_tick.prov;
                    tick.provisioned_onboard <= cur_tick.prov_onb;
                    tick.pair_request        <= cur_tick.pair_req;
                    tick.voice_active        <= cur_tick.voice;
                    tick.peer_link           <= cur_tick.peer;
                    tick.valid               <= 1'b1;
                    // occasional idle burst after this beat
                    if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
                end else begin
                    tick.valid <= 1'b0;
                end
            end
        end
    end

    // led monitor: checks each beat against the oldest owed one, stalls at random
    always @(posedge i_clk) begin : check_led
        t_led want;
        if (!i_rst_n) begin
            led.ready <= 1'b0;
        end else begin
            if (led.valid && led.ready) begin
                if (led_q.size() == 0) begin
                    $display("%0t: unexpected led beat, got mode %0d apply %0b",
                             $time, led.led_mode, led.apply);
                    errors++;
                end else begin
                    want = led_q.pop_front();
                    if (led.led_mode !== want.mode || led.apply !== want.apply) begin
                        $display({"%0t: led mismatch, expected mode %0d apply %0b,",
                                  " got mode %0d apply %0b"},
                                 $time, want.mode, want.apply, led.led_mode, led.apply);
                        errors++;
                    end
                end
            end
            if (stall != 0) stall--;
            else if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 16);
            led.ready <= !hold && stall == 0;
        end
    end

    // long receiver hold-off so the result register fills and the input stalls
    initial begin
        while (ticks_taken < 250) @(posedge i_clk);
        hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold <= 1'b0;
    end

    // stimulus: directed walk through the modes, then debounce phases
    initial begin
        while (i_rst_n !== 1'b1) @(posedge i_clk);

        // booting holds boot, then boot done without provisioning still holds it
        push_tick(LINK_CONNECTED,    8'b0000_0000);
        push_tick(LINK_OTHER,        8'b0011_1111);
        push_tick(LINK_CONNECTED,    8'b0100_0001);
        // pairing while unprovisioned leaves boot for pair
        push_tick(LINK_CONNECTED,    8'b0110_0000);
        // pair request and pairing without onboard marks keep pair
        push_tick(LINK_CONNECTED,    8'b0000_1100);
        push_tick(LINK_CONNECTED,    8'b0010_0001);
        // onboard marks with the link up (other counts as up) go to normal
        push_tick(LINK_OTHER,        8'b0000_1000);
        // voice on and off, peer link toggling
        push_tick(LINK_CONNECTED,    8'b0000_0010);
        push_tick(LINK_CONNECTED,    8'b0000_0011);
        push_tick(LINK_CONNECTED,    8'b0000_0001);
        // disconnect held past the debounce limit gives trouble
        repeat (6) push_tick(LINK_DISCONNECTED, 8'b0001_0001);
        // pause held past the limit gives paused
        repeat (6) push_tick(LINK_PAUSED, 8'b0001_0000);
        // pair request from paused, then every flag high
        push_tick(LINK_PAUSED,       8'b0000_0100);
        push_tick(LINK_CONNECTED,    8'b1111_1111);

        // debounce settings: one, maximum, zero, small, random, back to reset value
        run_phase(4'd1, 200);
        run_phase(4'd15, 200);
        run_phase(4'd0, 60);
        run_phase(4'd2, 200);
        repeat (3) run_phase(4'($urandom_range(1, 15)), 200);
        drain();
        calm <= 1'b1;
        run_phase(DebounceReset, 360);

        drain();
        repeat (4) @(posedge i_clk);
        if (errors == 0 && led_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
